// File: rtl/core/ibk_pkg.sv
`timescale 1ns / 1ps
package ibk_pkg;

    localparam int MAX_BOOKINGS = 1024;
    localparam int MAX_DOUBLES  = 1024;
    localparam int TIME_BITS    = 30;

    localparam int BK_IDX_W = $clog2(MAX_BOOKINGS);
    localparam int BK_CNT_W = $clog2(MAX_BOOKINGS + 1);
    localparam int DB_IDX_W = $clog2(MAX_DOUBLES);
    localparam int DB_CNT_W = $clog2(MAX_DOUBLES + 1);
    localparam int CMP_W    = (BK_CNT_W > DB_CNT_W) ? BK_CNT_W : DB_CNT_W;
    localparam int SPAN_W   = 2 * TIME_BITS;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_TRIPLE = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic [TIME_BITS-1:0] interval_start;
        logic [TIME_BITS-1:0] interval_end;
    } t_req;

    typedef struct packed {
        logic    accepted;
        t_status status;
    } t_rsp;

    typedef struct packed {
        logic [TIME_BITS-1:0] lo;
        logic [TIME_BITS-1:0] hi;
    } t_span;

    typedef struct packed {
        logic                we;
        logic [BK_IDX_W-1:0] waddr;
        t_span               wdata;
        logic [BK_IDX_W-1:0] raddr;
    } t_bk_cmd;

    typedef struct packed {
        logic                we;
        logic [DB_IDX_W-1:0] waddr;
        t_span               wdata;
        logic [DB_IDX_W-1:0] raddr;
    } t_db_cmd;

    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_seq_res;

endpackage

// File: rtl/core/ibk_ram.sv
`timescale 1ns / 1ps
module ibk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ibk_seq.sv
`timescale 1ns / 1ps
module ibk_seq
    import ibk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_req     i_req,
    output logic     o_busy,
    output t_bk_cmd  o_bk_cmd,
    input  t_span    i_bk_rdata,
    output t_db_cmd  o_db_cmd,
    input  t_span    i_db_rdata,
    output t_seq_res o_res,
    input  logic     i_res_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_BOOK,
        S_DONE
    } t_state;

    t_state              r_state;
    t_req                r_req;
    logic [BK_CNT_W-1:0] r_bcount;
    logic [DB_CNT_W-1:0] r_dcount;
    logic [CMP_W-1:0]    r_idx;
    logic                r_pend_b;
    logic                r_pend_d;
    logic                r_hit;
    logic [BK_CNT_W-1:0] r_need;
    t_rsp                r_rsp;
    logic                r_bk_we;
    logic                r_db_we;
    logic [DB_IDX_W-1:0] r_db_waddr;
    t_span               r_db_wdata;

    function automatic logic [TIME_BITS-1:0] tmax(logic [TIME_BITS-1:0] a,
                                                  logic [TIME_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [TIME_BITS-1:0] tmin(logic [TIME_BITS-1:0] a,
                                                  logic [TIME_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic             bk_meet;
    logic             db_meet;
    logic             idx_lt_b;
    logic             idx_lt_d;
    logic [CMP_W-1:0] room;
    logic             full;
    t_span            isect;

    assign isect.lo = tmax(i_bk_rdata.lo, r_req.interval_start);
    assign isect.hi = tmin(i_bk_rdata.hi, r_req.interval_end);
    assign bk_meet  = isect.lo < isect.hi;
    assign db_meet  = tmax(i_db_rdata.lo, r_req.interval_start)
                    < tmin(i_db_rdata.hi, r_req.interval_end);

    assign idx_lt_b = r_idx < CMP_W'(r_bcount);
    assign idx_lt_d = r_idx < CMP_W'(r_dcount);
    assign room     = CMP_W'(MAX_DOUBLES) - CMP_W'(r_dcount);
    assign full     = (CMP_W'(r_bcount) >= CMP_W'(MAX_BOOKINGS))
                   || (CMP_W'(r_need) > room);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bcount <= '0;
            r_dcount <= '0;
            r_pend_b <= 1'b0;
            r_pend_d <= 1'b0;
            r_bk_we  <= 1'b0;
            r_db_we  <= 1'b0;
        end else begin
            r_bk_we <= 1'b0;
            r_db_we <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req    <= i_req;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_need   <= '0;
                        r_pend_b <= 1'b0;
                        r_pend_d <= 1'b0;
                        if (i_req.interval_start >= i_req.interval_end) begin
                            r_rsp   <= '{accepted: 1'b1, status: ST_OK};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // data read last cycle arrives now
                    if (r_pend_d && db_meet) begin
                        r_hit <= 1'b1;
                    end
                    if (r_pend_b && bk_meet) begin
                        r_need <= r_need + BK_CNT_W'(1);
                    end
                    if (idx_lt_b || idx_lt_d) begin
                        r_pend_b <= idx_lt_b;
                        r_pend_d <= idx_lt_d;
                        r_idx    <= r_idx + CMP_W'(1);
                    end else begin
                        r_pend_b <= 1'b0;
                        r_pend_d <= 1'b0;
                        r_state  <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    priority if (r_hit) begin
                        r_rsp   <= '{accepted: 1'b0, status: ST_TRIPLE};
                        r_state <= S_DONE;
                    end else if (full) begin
                        r_rsp   <= '{accepted: 1'b0, status: ST_FULL};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    // append each overlap to the double table past its live entries
                    if (r_pend_b && bk_meet) begin
                        r_db_we    <= 1'b1;
                        r_db_waddr <= r_dcount[DB_IDX_W-1:0];
                        r_db_wdata <= isect;
                        r_dcount   <= r_dcount + DB_CNT_W'(1);
                    end
                    if (idx_lt_b) begin
                        r_pend_b <= 1'b1;
                        r_idx    <= r_idx + CMP_W'(1);
                    end else begin
                        r_pend_b <= 1'b0;
                        r_state  <= S_BOOK;
                    end
                end
                S_BOOK: begin
                    r_bk_we  <= 1'b1;
                    r_bcount <= r_bcount + BK_CNT_W'(1);
                    r_rsp    <= '{accepted: 1'b1, status: ST_OK};
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!i_res_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // booking write lands in the cycle after S_BOOK, at the old count
    logic [BK_IDX_W-1:0] bk_waddr;
    assign bk_waddr = BK_IDX_W'(r_bcount - BK_CNT_W'(1));

    assign o_busy = (r_state != S_IDLE);

    assign o_bk_cmd.we          = r_bk_we;
    assign o_bk_cmd.waddr       = bk_waddr;
    assign o_bk_cmd.wdata.lo    = r_req.interval_start;
    assign o_bk_cmd.wdata.hi    = r_req.interval_end;
    assign o_bk_cmd.raddr       = r_idx[BK_IDX_W-1:0];

    assign o_db_cmd.we          = r_db_we;
    assign o_db_cmd.waddr       = r_db_waddr;
    assign o_db_cmd.wdata       = r_db_wdata;
    assign o_db_cmd.raddr       = r_idx[DB_IDX_W-1:0];

    assign o_res.valid = (r_state == S_DONE);
    assign o_res.rsp   = r_rsp;

endmodule

// File: rtl/core/interval_booking_no_triple_overlap.sv
`timescale 1ns / 1ps
// Sequence: an empty request is accepted at once; a refused request first scans both
// tables, and a booked one scans them, makes a second pass over the booking table and
// then writes the booking.
// Throughput: one request at a time, set by the walk over both table memories, one entry
// per cycle on each read port, and, if it books, a second pass over the booking table.
// Reset: synchronous, active low; clears both counts, table contents stay as they are.
module interval_booking_no_triple_overlap
    import ibk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_bk_cmd  bk_cmd;
    t_db_cmd  db_cmd;
    t_span    bk_rdata;
    t_span    db_rdata;
    t_seq_res res;
    logic     res_stall;
    logic     busy;
    logic     r_rsp_valid;
    t_rsp     r_rsp;

    ibk_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_bk_cmd    (bk_cmd),
        .i_bk_rdata  (bk_rdata),
        .o_db_cmd    (db_cmd),
        .i_db_rdata  (db_rdata),
        .o_res       (res),
        .i_res_stall (res_stall)
    );

    ibk_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (MAX_BOOKINGS)
    ) u_bk_ram (
        .i_clk   (i_clk),
        .i_we    (bk_cmd.we),
        .i_waddr (bk_cmd.waddr),
        .i_wdata (bk_cmd.wdata),
        .i_raddr (bk_cmd.raddr),
        .o_rdata (bk_rdata)
    );

    ibk_ram #(
        .WIDTH (SPAN_W),
        .DEPTH (MAX_DOUBLES)
    ) u_db_ram (
        .i_clk   (i_clk),
        .i_we    (db_cmd.we),
        .i_waddr (db_cmd.waddr),
        .i_wdata (db_cmd.wdata),
        .i_raddr (db_cmd.raddr),
        .o_rdata (db_rdata)
    );

    // output register: hold the beat until the sink takes it
    assign res_stall = r_rsp_valid && i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (res.valid && !res_stall) begin
            r_rsp_valid <= 1'b1;
            r_rsp       <= res.rsp;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_req_stall = busy;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> o_req_stall)
        else $error("sequencer idle right after taking a request");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && !res_stall) |=> (o_rsp_valid && o_rsp == $past(res.rsp)))
        else $error("finished result not moved to output register");

    a_status_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.accepted == (o_rsp.status == ST_OK)))
        else $error("accepted flag disagrees with status");

endmodule
